/* src/hsv2rgb_pkg.sv */
// Shared constants, channel types and the hue wheel function for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  localparam logic WheelSix   = 1'b0;
  localparam logic WheelThree = 1'b1;

  localparam logic [15:0] Seg1      = 16'd255;
  localparam logic [15:0] Seg2      = 16'd510;
  localparam logic [15:0] Seg3      = 16'd765;
  localparam logic [15:0] Seg4      = 16'd1020;
  localparam logic [15:0] Seg5      = 16'd1275;
  localparam logic [15:0] Wheel6Len = 16'd1530;
  localparam logic [15:0] Wheel3Len = 16'd765;

  localparam logic [7:0]  FullScale = 8'd255;
  localparam logic [15:0] FullSq    = 16'd65025;
  // floor(2^32 / 65025); the quotient estimate is low by at most one
  localparam logic [16:0] RecipSq   = 17'd66051;
  localparam int unsigned RecipShift = 32;

  typedef logic [NumChan-1:0][7:0]  chan8_t;
  typedef logic [NumChan-1:0][15:0] chan16_t;
  typedef logic [NumChan-1:0][23:0] chan24_t;

  // Pure color on the selected wheel: each channel 0, 255 or a linear ramp
  function automatic chan8_t wheel_color(logic mode, logic [15:0] h);
    chan8_t c;
    logic [15:0] up1, up2, up4, dn2, dn3, dn4, dn6;
    up1 = h - Seg1;
    up2 = h - Seg2;
    up4 = h - Seg4;
    dn2 = Seg2 - h;
    dn3 = Seg3 - h;
    dn4 = Seg4 - h;
    dn6 = Wheel6Len - h;
    c = '0;
    if (mode == WheelSix) begin
      if (h < Seg1) begin
        c[ChRed] = FullScale; c[ChGreen] = h[7:0];
      end else if (h < Seg2) begin
        c[ChRed] = dn2[7:0]; c[ChGreen] = FullScale;
      end else if (h < Seg3) begin
        c[ChGreen] = FullScale; c[ChBlue] = up2[7:0];
      end else if (h < Seg4) begin
        c[ChGreen] = dn4[7:0]; c[ChBlue] = FullScale;
      end else if (h < Seg5) begin
        c[ChRed] = up4[7:0]; c[ChBlue] = FullScale;
      end else if (h < Wheel6Len) begin
        c[ChRed] = FullScale; c[ChBlue] = dn6[7:0];
      end
    end else begin
      if (h < Seg1) begin
        c[ChRed] = FullScale - h[7:0]; c[ChGreen] = h[7:0];
      end else if (h < Seg2) begin
        c[ChGreen] = dn2[7:0]; c[ChBlue] = up1[7:0];
      end else if (h < Wheel3Len) begin
        c[ChRed] = up2[7:0]; c[ChBlue] = dn3[7:0];
      end
    end
    return c;
  endfunction

endpackage

/* src/hsv_to_rgb_converter.sv */
// Pipelined HSV to RGB converter with selectable six- or three-segment hue wheel.
// Each accepted request passes through five register stages; the last of them is the
// output register, which holds the result until it is taken.
// Throughput: one pixel per clock; the five stages advance together and hold on stall.
// Reset (rst, synchronous, active high): clears all stage valid bits and sets
// wheel_mode to the six-segment wheel. Payload registers are not reset.
// Stage cost: wheel lookup, one 8x8 multiply, one 16x8 multiply, one 24x17 multiply,
// one 8x16 multiply with compare, per channel.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // wheel_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] hue, [23:16] saturation, [31:24] brightness
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import hsv2rgb_pkg::*;

  // Configuration: current hue wheel
  logic wheel_mode;

  // Stage valid bits
  logic v1, v2, v3, v4, v5;
  // Whole pipe advances when the output slot is free or being drained
  logic adv;

  // Stage 1: pure color plus saturation and brightness
  chan8_t     color1;
  logic [7:0] sat1, bri1;
  // Stage 2: saturation applied, numerator term before brightness
  chan16_t    term2;
  logic [7:0] bri2;
  // Stage 3: full numerator
  chan24_t    acc3;
  // Stage 4: quotient estimate and the numerator it came from
  chan8_t     quot4;
  chan24_t    acc4;
  // Stage 5: corrected result
  chan8_t     res5;

  // Combinational per-stage values
  chan8_t      color_next;
  chan16_t     term_next;
  chan24_t     acc_next;
  chan8_t      quot_next;
  chan8_t      res_next;
  logic [15:0] sat_w;
  logic [15:0] base;
  logic [40:0] recip_prod [NumChan];
  logic [23:0] back_prod  [NumChan];
  logic [23:0] remainder  [NumChan];
  logic [15:0] cs_prod    [NumChan];

  assign adv           = m_axis_tready || !v5;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {res5[ChBlue], res5[ChGreen], res5[ChRed]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode <= WheelSix;
    end else if (cfg_we) begin
      wheel_mode <= cfg_wdata;
    end
  end

  // Stage 1 logic: hue past the wheel leaves all channels at zero
  assign color_next = wheel_color(wheel_mode, s_axis_tdata[15:0]);

  // Stage 2 logic: c*s + 65025 - 255*s, never above 65025
  assign sat_w = {8'd0, sat1};
  assign base  = FullSq - ((sat_w << 8) - sat_w);

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      cs_prod[i]    = {8'd0, color1[i]} * sat_w;
      term_next[i]  = cs_prod[i] + base;
      // Stage 3 logic: times brightness, fits 24 bits
      acc_next[i]   = {8'd0, term2[i]} * {16'd0, bri2};
      // Stage 4 logic: reciprocal multiply, quotient is exact or one low
      recip_prod[i] = {17'd0, acc3[i]} * {24'd0, RecipSq};
      quot_next[i]  = recip_prod[i][RecipShift +: 8];
      // Stage 5 logic: bump the quotient when the remainder reaches the divisor
      back_prod[i]  = {16'd0, quot4[i]} * {8'd0, FullSq};
      remainder[i]  = acc4[i] - back_prod[i];
      res_next[i]   = (remainder[i] >= {8'd0, FullSq}) ? quot4[i] + 8'd1 : quot4[i];
    end
  end

  // Valid bits travel with the data; hold everything while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color1 <= color_next;
      sat1   <= s_axis_tdata[23:16];
      bri1   <= s_axis_tdata[31:24];
      term2  <= term_next;
      bri2   <= bri1;
      acc3   <= acc_next;
      quot4  <= quot_next;
      acc4   <= acc3;
      res5   <= res_next;
    end
  end

endmodule
